// ----- src/gps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, codes and helper functions for the gantry pick sequencer.
// ----------------------------------------------------------------------------
package gps_pkg;

  // Opcodes carried in the slave-side tuser
  localparam logic [3:0] OP_STOP     = 4'd0;
  localparam logic [3:0] OP_UP       = 4'd1;
  localparam logic [3:0] OP_DOWN     = 4'd2;
  localparam logic [3:0] OP_FORWARD  = 4'd3;
  localparam logic [3:0] OP_BACKWARD = 4'd4;
  localparam logic [3:0] OP_GOTO_ROW = 4'd5;
  localparam logic [3:0] OP_PICK     = 4'd6;
  localparam logic [3:0] OP_RESET    = 4'd7;
  localparam logic [3:0] OP_CLEAR    = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] REG_SPEED        = 3'd0;
  localparam logic [2:0] REG_Y_UPPER      = 3'd1;
  localparam logic [2:0] REG_Z_FRONT      = 3'd2;
  localparam logic [2:0] REG_Z_BACK       = 3'd3;
  localparam logic [2:0] REG_Z_RETRACT    = 3'd4;
  localparam logic [2:0] REG_LIFT_OFFSET  = 3'd5;
  localparam logic [2:0] REG_SECOND_DELAY = 3'd6;
  localparam logic [2:0] REG_REACH_START  = 3'd7;

  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 64;
  localparam int M_TDATA_W   = 32;

  // Reset values of the configuration registers
  localparam logic [7:0]  SPEED_RST        = 8'd255;
  localparam logic [13:0] Y_UPPER_RST      = 14'd5000;
  localparam logic [11:0] Z_FRONT_RST      = 12'd875;
  localparam logic [11:0] Z_BACK_RST       = 12'd407;
  localparam logic [11:0] Z_RETRACT_RST    = 12'd410;
  localparam logic [11:0] LIFT_OFFSET_RST  = 12'd300;
  localparam logic [15:0] SECOND_DELAY_RST = 16'd2000;
  localparam logic [11:0] REACH_START_RST  = 12'd870;

  localparam logic [7:0]  DUTY_IDLE   = 8'd255;
  localparam logic [11:0] REACH_STEP  = 12'd200;
  localparam logic [11:0] REACH_FLOOR = 12'd500;

  // One motor axis: direction pin, brake pin and PWM duty
  typedef struct packed {
    logic       dir;
    logic       brake;
    logic [7:0] duty;
  } axis_t;

  // Result transaction; the last member sits in the lowest bits
  typedef struct packed {
    logic [1:0] picked_count;
    logic       has_moved;
    logic       product_picked;
    logic       picked_event;
    logic [7:0] z_duty;
    logic       z_brake;
    logic       z_direction;
    logic [7:0] y_duty;
    logic       y_brake;
    logic       y_direction;
  } res_t;

  // Stopping an axis engages its brake and parks the duty; direction is kept.
  function automatic axis_t axis_halt(input axis_t a);
    axis_t r;
    r       = a;
    r.brake = 1'b1;
    r.duty  = DUTY_IDLE;
    return r;
  endfunction

  function automatic axis_t axis_move(input logic dir, input logic [7:0] duty);
    axis_t r;
    r.dir   = dir;
    r.brake = 1'b0;
    r.duty  = duty;
    return r;
  endfunction

  // Encoder target of each row; rows outside one to five give zero.
  function automatic logic [13:0] row_target(input logic [2:0] row);
    logic [13:0] t;
    case (row)
      3'd1:    t = 14'd150;
      3'd2:    t = 14'd1200;
      3'd3:    t = 14'd2250;
      3'd4:    t = 14'd3300;
      3'd5:    t = 14'd4350;
      default: t = 14'd0;
    endcase
    return t;
  endfunction

  // Fork reach after the given number of counted picks, held at the floor.
  function automatic logic [11:0] fork_reach(input logic [11:0] start,
                                             input logic [1:0]  tally);
    logic [11:0] r;
    r = start;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < tally) begin
        if (r < REACH_FLOOR + REACH_STEP) begin
          r = REACH_FLOOR;
        end else begin
          r = r - REACH_STEP;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/gantry_pick_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gantry_pick_sequencer
// Control tick processor for a two-axis pick robot (lift and fork).
// ----------------------------------------------------------------------------
// The block accepts one control tick per clock cycle while the result side
// is not stalled and returns one result transaction per tick. The tick waits
// in the input register while the compare and flag update logic computes the
// new axis state, which is written to the state registers and the result
// register together when the tick advances. The state update of a tick is
// complete with that write, so the next tick follows directly. The
// result register holds while the master side stalls and the input register
// keeps taking a tick until both are full. Configuration writes take effect
// at the clock edge of the write and should be made while no tick is in
// flight.
module gantry_pick_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [gps_pkg::CFG_DATA_W-1:0] cfg_data,
  // Tick input
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // s_tdata, from bit 0: target_row[2:0], y_position[13:0], z_distance[11:0],
  // now_ms[31:0], zero fill
  input  wire logic [gps_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: opcode[3:0]
  input  wire logic [3:0]  s_tuser,
  // Result output
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, from bit 0: y_direction, y_brake, y_duty[7:0], z_direction,
  // z_brake, z_duty[7:0], picked_event, product_picked, has_moved,
  // picked_count[1:0], zero fill
  output      logic [gps_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int RES_W = $bits(gps_pkg::res_t);

  // Configuration registers
  logic [7:0]  speed;
  logic [13:0] y_upper_limit;
  logic [11:0] z_front_limit;
  logic [11:0] z_back_limit;
  logic [11:0] z_retract_target;
  logic [11:0] lift_offset;
  logic [15:0] second_count_delay;
  logic [11:0] reach_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed              <= gps_pkg::SPEED_RST;
      y_upper_limit      <= gps_pkg::Y_UPPER_RST;
      z_front_limit      <= gps_pkg::Z_FRONT_RST;
      z_back_limit       <= gps_pkg::Z_BACK_RST;
      z_retract_target   <= gps_pkg::Z_RETRACT_RST;
      lift_offset        <= gps_pkg::LIFT_OFFSET_RST;
      second_count_delay <= gps_pkg::SECOND_DELAY_RST;
      reach_start        <= gps_pkg::REACH_START_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gps_pkg::REG_SPEED:        speed              <= cfg_data[7:0];
        gps_pkg::REG_Y_UPPER:      y_upper_limit      <= cfg_data[13:0];
        gps_pkg::REG_Z_FRONT:      z_front_limit      <= cfg_data[11:0];
        gps_pkg::REG_Z_BACK:       z_back_limit       <= cfg_data[11:0];
        gps_pkg::REG_Z_RETRACT:    z_retract_target   <= cfg_data[11:0];
        gps_pkg::REG_LIFT_OFFSET:  lift_offset        <= cfg_data[11:0];
        gps_pkg::REG_SECOND_DELAY: second_count_delay <= cfg_data[15:0];
        gps_pkg::REG_REACH_START:  reach_start        <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake
  logic        in_valid;
  logic [3:0]  in_op;
  logic [2:0]  in_row;
  logic [13:0] in_y;
  logic [11:0] in_z;
  logic [31:0] in_now;
  logic        out_valid;
  logic        advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= s_tuser;
      in_row <= s_tdata[2:0];
      in_y   <= s_tdata[16:3];
      in_z   <= s_tdata[28:17];
      in_now <= s_tdata[60:29];
    end
  end

  // Machine state
  gps_pkg::axis_t lift, fork_axis;
  logic [13:0] base_height;
  logic        holding;
  logic        pick_done;
  logic        row_reached;
  logic [31:0] first_count_time;
  logic [1:0]  pick_tally;
  logic        counted_once;
  logic        counted_twice;

  gps_pkg::axis_t lift_next, fork_axis_next;
  logic [13:0] base_height_next;
  logic        holding_next;
  logic        pick_done_next;
  logic        row_reached_next;
  logic [31:0] first_count_time_next;
  logic [1:0]  pick_tally_next;
  logic        counted_once_next;
  logic        counted_twice_next;
  logic        event_next;

  // One tick: compares against limits and targets, then flag updates
  always_comb begin
    logic [13:0] bh;
    logic [13:0] tgt;
    logic [14:0] lift_top;
    logic [11:0] reach;
    logic [31:0] elapsed;

    lift_next             = lift;
    fork_axis_next        = fork_axis;
    base_height_next      = base_height;
    holding_next          = holding;
    pick_done_next        = pick_done;
    row_reached_next      = row_reached;
    first_count_time_next = first_count_time;
    pick_tally_next       = pick_tally;
    counted_once_next     = counted_once;
    counted_twice_next    = counted_twice;
    event_next            = 1'b0;

    bh       = (base_height == 14'd0) ? in_y : base_height;
    tgt      = gps_pkg::row_target(in_row);
    lift_top = {1'b0, bh} + {3'b000, lift_offset};
    reach    = gps_pkg::fork_reach(reach_start, pick_tally);
    elapsed  = in_now - first_count_time;

    unique case (in_op)
      gps_pkg::OP_STOP: begin
        lift_next      = gps_pkg::axis_halt(lift);
        fork_axis_next = gps_pkg::axis_halt(fork_axis);
      end
      gps_pkg::OP_UP: begin
        if (in_y < y_upper_limit) begin
          lift_next = gps_pkg::axis_move(1'b0, speed);
        end else begin
          lift_next      = gps_pkg::axis_halt(lift);
          fork_axis_next = gps_pkg::axis_halt(fork_axis);
        end
      end
      gps_pkg::OP_DOWN: begin
        lift_next = gps_pkg::axis_move(1'b1, speed);
      end
      gps_pkg::OP_FORWARD: begin
        if (in_z < z_front_limit) begin
          fork_axis_next = gps_pkg::axis_move(1'b0, speed);
        end else begin
          lift_next      = gps_pkg::axis_halt(lift);
          fork_axis_next = gps_pkg::axis_halt(fork_axis);
        end
      end
      gps_pkg::OP_BACKWARD: begin
        if (in_z > z_back_limit) begin
          fork_axis_next = gps_pkg::axis_move(1'b1, speed);
        end else begin
          lift_next      = gps_pkg::axis_halt(lift);
          fork_axis_next = gps_pkg::axis_halt(fork_axis);
        end
      end
      gps_pkg::OP_GOTO_ROW: begin
        // Rows outside one to five leave everything as it was.
        if (in_row >= 3'd1 && in_row <= 3'd5) begin
          if (tgt > in_y && !row_reached) begin
            if (in_y < y_upper_limit) begin
              lift_next = gps_pkg::axis_move(1'b0, speed);
            end else begin
              lift_next      = gps_pkg::axis_halt(lift);
              fork_axis_next = gps_pkg::axis_halt(fork_axis);
            end
          end else if (tgt < in_y && !row_reached) begin
            lift_next = gps_pkg::axis_move(1'b1, speed);
          end else begin
            row_reached_next = 1'b1;
          end
        end
      end
      gps_pkg::OP_PICK: begin
        if (pick_done) begin
          lift_next      = gps_pkg::axis_halt(lift);
          fork_axis_next = gps_pkg::axis_halt(fork_axis);
        end else begin
          base_height_next = bh;
          if (!holding) begin
            if (in_z < reach) begin
              // Lift stops while the fork reaches out.
              lift_next = gps_pkg::axis_halt(lift);
              if (in_z < z_front_limit) begin
                fork_axis_next = gps_pkg::axis_move(1'b0, speed);
              end else begin
                fork_axis_next = gps_pkg::axis_halt(fork_axis);
              end
            end else if ({1'b0, in_y} < lift_top) begin
              if (in_y < y_upper_limit) begin
                lift_next = gps_pkg::axis_move(1'b0, speed);
              end else begin
                lift_next      = gps_pkg::axis_halt(lift);
                fork_axis_next = gps_pkg::axis_halt(fork_axis);
              end
            end else begin
              lift_next      = gps_pkg::axis_halt(lift);
              fork_axis_next = gps_pkg::axis_halt(fork_axis);
              holding_next   = 1'b1;
            end
          end else begin
            if (in_z > z_retract_target) begin
              if (in_z > z_back_limit) begin
                fork_axis_next = gps_pkg::axis_move(1'b1, speed);
              end else begin
                lift_next      = gps_pkg::axis_halt(lift);
                fork_axis_next = gps_pkg::axis_halt(fork_axis);
              end
            end else if (in_y > bh) begin
              lift_next = gps_pkg::axis_move(1'b1, speed);
            end else begin
              lift_next      = gps_pkg::axis_halt(lift);
              fork_axis_next = gps_pkg::axis_halt(fork_axis);
              pick_done_next = 1'b1;
              holding_next   = 1'b0;
              event_next     = 1'b1;
            end
          end
        end
      end
      gps_pkg::OP_RESET: begin
        row_reached_next = 1'b0;
        holding_next     = 1'b0;
        pick_done_next   = 1'b0;
        base_height_next = 14'd0;
        // First count at once, the second only after the delay has passed.
        if (!counted_once && !counted_twice) begin
          pick_tally_next       = pick_tally + 2'd1;
          counted_once_next     = 1'b1;
          first_count_time_next = in_now;
        end else if (!counted_twice && counted_once &&
                     elapsed > {16'd0, second_count_delay}) begin
          pick_tally_next    = pick_tally + 2'd1;
          counted_twice_next = 1'b1;
        end
      end
      gps_pkg::OP_CLEAR: begin
        row_reached_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lift             <= '{dir: 1'b0, brake: 1'b1, duty: gps_pkg::DUTY_IDLE};
      fork_axis        <= '{dir: 1'b0, brake: 1'b1, duty: gps_pkg::DUTY_IDLE};
      base_height      <= 14'd0;
      holding          <= 1'b0;
      pick_done        <= 1'b0;
      row_reached      <= 1'b0;
      first_count_time <= 32'd0;
      pick_tally       <= 2'd0;
      counted_once     <= 1'b0;
      counted_twice    <= 1'b0;
    end else if (advance) begin
      lift             <= lift_next;
      fork_axis        <= fork_axis_next;
      base_height      <= base_height_next;
      holding          <= holding_next;
      pick_done        <= pick_done_next;
      row_reached      <= row_reached_next;
      first_count_time <= first_count_time_next;
      pick_tally       <= pick_tally_next;
      counted_once     <= counted_once_next;
      counted_twice    <= counted_twice_next;
    end
  end

  // Result register
  gps_pkg::res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res.y_direction    <= lift_next.dir;
      out_res.y_brake        <= lift_next.brake;
      out_res.y_duty         <= lift_next.duty;
      out_res.z_direction    <= fork_axis_next.dir;
      out_res.z_brake        <= fork_axis_next.brake;
      out_res.z_duty         <= fork_axis_next.duty;
      out_res.picked_event   <= event_next;
      out_res.product_picked <= pick_done_next;
      out_res.has_moved      <= row_reached_next;
      out_res.picked_count   <= pick_tally_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(gps_pkg::M_TDATA_W-RES_W){1'b0}}, out_res};

endmodule
`default_nettype wire

// ----- src/gantry_pick_sequencer_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gantry_pick_sequencer_checker
// Port-level checks on the result stream of the gantry pick sequencer.
// ----------------------------------------------------------------------------
module gantry_pick_sequencer_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [gps_pkg::M_TDATA_W-1:0] m_tdata
);

  gps_pkg::res_t res;
  assign res = m_tdata[$bits(gps_pkg::res_t)-1:0];

  // A stalled result transaction stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result transaction changed while stalled");

  // A completed pick always reports the picked flag with it.
  a_event_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.picked_event |-> res.product_picked)
    else $error("pick event without picked flag");

  // The tally is counted at most twice.
  a_tally: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.picked_count != 2'd3)
    else $error("picked count beyond two");

  // An engaged brake always comes with the parked duty on that axis.
  a_brake_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!res.y_brake || res.y_duty == gps_pkg::DUTY_IDLE) &&
                 (!res.z_brake || res.z_duty == gps_pkg::DUTY_IDLE))
    else $error("brake engaged with a running duty");

  // Nothing is offered in the cycle after a reset edge.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind gantry_pick_sequencer gantry_pick_sequencer_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gantry pick sequencer. Control ticks are queued
// by a stimulus process and offered by a clocked driver. Every accepted tick
// advances a local model of the lift, the fork and the pick flags. A clocked
// monitor compares each result transaction, field by field, with the oldest
// predicted status. Both sides idle at random, and the configuration changes
// between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RES_W        = $bits(gps_pkg::res_t);
  localparam int WATCHDOG_MAX = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int SEG_ITEMS    = 216;
  localparam int MAX_PRINTS   = 40;
  localparam int Y_MAX        = 16383;
  localparam int Z_MAX        = 4095;
  localparam logic [3:0] OP_UNUSED_TOP = 4'd15;
  localparam logic [2:0] ROW_FIRST     = 3'd1;
  localparam logic [2:0] ROW_LAST      = 3'd5;

  // One control tick as queued for the driver
  typedef struct {
    logic [3:0]  opcode;
    logic [2:0]  row;
    logic [13:0] y_pos;
    logic [11:0] z_dist;
    logic [31:0] now_ms;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [gps_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [gps_pkg::M_TDATA_W-1:0] m_tdata;

  gantry_pick_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the configuration registers
  logic [7:0]  speed_setting        = gps_pkg::SPEED_RST;
  logic [13:0] y_upper_setting      = gps_pkg::Y_UPPER_RST;
  logic [11:0] z_front_setting      = gps_pkg::Z_FRONT_RST;
  logic [11:0] z_back_setting       = gps_pkg::Z_BACK_RST;
  logic [11:0] z_retract_setting    = gps_pkg::Z_RETRACT_RST;
  logic [11:0] lift_offset_setting  = gps_pkg::LIFT_OFFSET_RST;
  logic [15:0] second_delay_setting = gps_pkg::SECOND_DELAY_RST;
  logic [11:0] reach_start_setting  = gps_pkg::REACH_START_RST;

  // Predicted machine state
  gps_pkg::axis_t lift_axis = '{dir: 1'b0, brake: 1'b1, duty: gps_pkg::DUTY_IDLE};
  gps_pkg::axis_t fork_axis = '{dir: 1'b0, brake: 1'b1, duty: gps_pkg::DUTY_IDLE};
  logic [13:0] grip_height    = '0;
  logic        load_held      = 1'b0;
  logic        pick_over      = 1'b0;
  logic        row_arrived    = 1'b0;
  logic [31:0] first_count_ms = '0;
  logic [1:0]  count_total    = '0;
  logic        first_counted  = 1'b0;
  logic        second_counted = 1'b0;

  tick_t         tick_queue[$];
  gps_pkg::res_t expected_axis_status[$];
  tick_t         offered_tick;
  logic [31:0] clock_ms = '0;
  int queued_count  = 0;
  int checked_count = 0;
  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Encoder count of each row; zero outside the valid rows.
  function automatic logic [13:0] row_encoder_goal(input logic [2:0] row);
    case (row)
      3'd1:    return 14'd150;
      3'd2:    return 14'd1200;
      3'd3:    return 14'd2250;
      3'd4:    return 14'd3300;
      3'd5:    return 14'd4350;
      default: return 14'd0;
    endcase
  endfunction

  function automatic void park_axes();
    lift_axis.brake = 1'b1;
    lift_axis.duty  = gps_pkg::DUTY_IDLE;
    fork_axis.brake = 1'b1;
    fork_axis.duty  = gps_pkg::DUTY_IDLE;
  endfunction

  function automatic void raise_lift(input logic [13:0] y);
    if (y < y_upper_setting) begin
      lift_axis = '{dir: 1'b0, brake: 1'b0, duty: speed_setting};
    end else begin
      park_axes();
    end
  endfunction

  function automatic void lower_lift();
    lift_axis = '{dir: 1'b1, brake: 1'b0, duty: speed_setting};
  endfunction

  function automatic void extend_fork(input logic [11:0] z);
    if (z < z_front_setting) begin
      fork_axis = '{dir: 1'b0, brake: 1'b0, duty: speed_setting};
    end else begin
      park_axes();
    end
  endfunction

  function automatic void retract_fork(input logic [11:0] z);
    if (z > z_back_setting) begin
      fork_axis = '{dir: 1'b1, brake: 1'b0, duty: speed_setting};
    end else begin
      park_axes();
    end
  endfunction

  // Reach shrinks by one step per counted pick and never drops below the floor.
  function automatic int reach_now();
    int r;
    r = int'(reach_start_setting);
    for (int i = 0; i < int'(count_total); i++) begin
      r = r - int'(gps_pkg::REACH_STEP);
      if (r < int'(gps_pkg::REACH_FLOOR)) r = int'(gps_pkg::REACH_FLOOR);
    end
    return r;
  endfunction

  // One pick step; returns one on the tick that completes the pick.
  function automatic logic pick_tick(input logic [13:0] y, input logic [11:0] z);
    if (pick_over) begin
      park_axes();
      return 1'b0;
    end
    if (grip_height == '0) grip_height = y;
    if (!load_held) begin
      if (int'(z) < reach_now()) begin
        park_axes();
        extend_fork(z);
      end else if (int'(y) < int'(grip_height) + int'(lift_offset_setting)) begin
        raise_lift(y);
      end else begin
        park_axes();
        load_held = 1'b1;
      end
    end else begin
      if (z > z_retract_setting) begin
        retract_fork(z);
      end else if (y > grip_height) begin
        lower_lift();
      end else begin
        park_axes();
        pick_over = 1'b1;
        load_held = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Post-pick clear; the tally counts once, then once more after the delay.
  function automatic void pick_rearm(input logic [31:0] now);
    logic [31:0] elapsed;
    elapsed     = now - first_count_ms;
    row_arrived = 1'b0;
    load_held   = 1'b0;
    pick_over   = 1'b0;
    grip_height = '0;
    if (!first_counted && !second_counted) begin
      count_total    = count_total + 2'd1;
      first_counted  = 1'b1;
      first_count_ms = now;
    end else if (!second_counted && first_counted &&
                 elapsed > {16'd0, second_delay_setting}) begin
      count_total    = count_total + 2'd1;
      second_counted = 1'b1;
    end
  endfunction

  function automatic gps_pkg::res_t next_gantry_status(input tick_t t);
    gps_pkg::res_t r;
    logic          done;
    logic [13:0]   goal;
    done = 1'b0;
    goal = row_encoder_goal(t.row);
    case (t.opcode)
      gps_pkg::OP_STOP:     park_axes();
      gps_pkg::OP_UP:       raise_lift(t.y_pos);
      gps_pkg::OP_DOWN:     lower_lift();
      gps_pkg::OP_FORWARD:  extend_fork(t.z_dist);
      gps_pkg::OP_BACKWARD: retract_fork(t.z_dist);
      gps_pkg::OP_GOTO_ROW: begin
        if (t.row >= ROW_FIRST && t.row <= ROW_LAST) begin
          if (goal > t.y_pos && !row_arrived) begin
            raise_lift(t.y_pos);
          end else if (goal < t.y_pos && !row_arrived) begin
            lower_lift();
          end else begin
            row_arrived = 1'b1;
          end
        end
      end
      gps_pkg::OP_PICK:     done = pick_tick(t.y_pos, t.z_dist);
      gps_pkg::OP_RESET:    pick_rearm(t.now_ms);
      gps_pkg::OP_CLEAR:    row_arrived = 1'b0;
      default:              ;
    endcase
    r.y_direction    = lift_axis.dir;
    r.y_brake        = lift_axis.brake;
    r.y_duty         = lift_axis.duty;
    r.z_direction    = fork_axis.dir;
    r.z_brake        = fork_axis.brake;
    r.z_duty         = fork_axis.duty;
    r.picked_event   = done;
    r.product_picked = pick_over;
    r.has_moved      = row_arrived;
    r.picked_count   = count_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
               $realtime, what, checked_count, got, want);
    end
  endtask

  task automatic check_result(input gps_pkg::res_t got);
    gps_pkg::res_t want;
    if (expected_axis_status.size() == 0) begin
      report_mismatch("result with nothing expected", int'(got), 0);
      return;
    end
    want = expected_axis_status.pop_front();
    if (got.y_direction !== want.y_direction)
      report_mismatch("y_direction", got.y_direction, want.y_direction);
    if (got.y_brake !== want.y_brake)
      report_mismatch("y_brake", got.y_brake, want.y_brake);
    if (got.y_duty !== want.y_duty)
      report_mismatch("y_duty", got.y_duty, want.y_duty);
    if (got.z_direction !== want.z_direction)
      report_mismatch("z_direction", got.z_direction, want.z_direction);
    if (got.z_brake !== want.z_brake)
      report_mismatch("z_brake", got.z_brake, want.z_brake);
    if (got.z_duty !== want.z_duty)
      report_mismatch("z_duty", got.z_duty, want.z_duty);
    if (got.picked_event !== want.picked_event)
      report_mismatch("picked_event", got.picked_event, want.picked_event);
    if (got.product_picked !== want.product_picked)
      report_mismatch("product_picked", got.product_picked, want.product_picked);
    if (got.has_moved !== want.has_moved)
      report_mismatch("has_moved", got.has_moved, want.has_moved);
    if (got.picked_count !== want.picked_count)
      report_mismatch("picked_count", got.picked_count, want.picked_count);
    checked_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver, monitor and watchdog
  // --------------------------------------------------------------------------

  // Offers queued ticks; the status is predicted when a transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_axis_status.push_back(next_gantry_status(offered_tick));
      end
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_tick = tick_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, offered_tick.now_ms, offered_tick.z_dist,
                       offered_tick.y_pos, offered_tick.row};
          s_tuser  <= offered_tick.opcode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Takes result transactions; a requested hold-off keeps tready low for a while.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(gps_pkg::res_t'(m_tdata[RES_W-1:0]));
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_served + 1;
        hold_left   = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("gantry_pick_sequencer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic queue_tick_at(input logic [3:0] op, input int row, input int y,
                               input int z, input logic [31:0] now);
    tick_t t;
    clock_ms = now;
    t.opcode = op;
    t.row    = 3'(row);
    t.y_pos  = 14'(y);
    t.z_dist = 12'(z);
    t.now_ms = now;
    tick_queue.push_back(t);
    queued_count++;
  endtask

  task automatic queue_tick(input logic [3:0] op, input int row, input int y,
                            input int z);
    queue_tick_at(op, row, y, z, clock_ms + 32'($urandom_range(40)));
  endtask

  // A complete pick: reach out, lift, retract, lower, then clear for the next.
  task automatic queue_pick_run();
    int base, top, steps, zs, zlow;
    logic [31:0] gap;
    base = $urandom_range(Y_MAX - int'(lift_offset_setting), 1);
    top  = base + int'(lift_offset_setting);
    repeat ($urandom_range(3)) queue_tick(gps_pkg::OP_PICK, $urandom_range(7), base,
                                          $urandom_range(600));
    steps = $urandom_range(3, 1);
    for (int k = 0; k < steps; k++)
      queue_tick(gps_pkg::OP_PICK, $urandom_range(7),
                 base + (int'(lift_offset_setting) * k) / steps,
                 $urandom_range(Z_MAX, 4000));
    queue_tick(gps_pkg::OP_PICK, $urandom_range(7), clamp(top + $urandom_range(2), Y_MAX),
               $urandom_range(Z_MAX, 4000));
    if (z_retract_setting < 12'(Z_MAX)) begin
      zs    = clamp(int'(z_retract_setting) + $urandom_range(400, 1), Z_MAX);
      steps = $urandom_range(3, 1);
      for (int k = 0; k < steps; k++)
        queue_tick(gps_pkg::OP_PICK, $urandom_range(7), top,
                   zs - ((zs - int'(z_retract_setting) - 1) * k) / steps);
    end
    zlow  = clamp(int'(z_retract_setting) - $urandom_range(3), Z_MAX);
    steps = $urandom_range(3, 1);
    for (int k = 0; k < steps; k++)
      queue_tick(gps_pkg::OP_PICK, $urandom_range(7),
                 top - (int'(lift_offset_setting) * k) / steps, zlow);
    queue_tick(gps_pkg::OP_PICK, $urandom_range(7), base - $urandom_range(1), zlow);
    repeat ($urandom_range(1)) queue_tick(gps_pkg::OP_PICK, $urandom_range(7), base, zlow);
    case ($urandom_range(3))
      0:       gap = 32'($urandom_range(100));
      1:       gap = {16'd0, second_delay_setting};
      2:       gap = {16'd0, second_delay_setting} + 32'd1;
      default: gap = 32'($urandom_range(200000));
    endcase
    queue_tick_at(gps_pkg::OP_RESET, $urandom_range(7), $urandom_range(Y_MAX),
                  $urandom_range(Z_MAX), clock_ms + gap);
  endtask

  // Clear the flag, approach a row in up to four ticks, land on it, then sometimes clear the flag again.
  task automatic queue_row_run();
    int row, goal, y, steps;
    row   = $urandom_range(5, 1);
    goal  = int'(row_encoder_goal(3'(row)));
    y     = $urandom_range(Y_MAX);
    steps = $urandom_range(4, 1);
    queue_tick(gps_pkg::OP_CLEAR, row, y, $urandom_range(Z_MAX));
    for (int k = 0; k < steps; k++)
      queue_tick(gps_pkg::OP_GOTO_ROW, row, y + ((goal - y) * k) / steps,
                 $urandom_range(Z_MAX));
    queue_tick(gps_pkg::OP_GOTO_ROW, row, goal, $urandom_range(Z_MAX));
    queue_tick(gps_pkg::OP_GOTO_ROW, $urandom_range(7), $urandom_range(Y_MAX),
               $urandom_range(Z_MAX));
    if ($urandom_range(1) == 0)
      queue_tick(gps_pkg::OP_CLEAR, row, goal, $urandom_range(Z_MAX));
  endtask

  // Any opcode, with readings either anywhere or close to a limit.
  task automatic queue_noise();
    int y, z;
    y = $urandom_range(1) ? $urandom_range(Y_MAX)
                          : clamp(int'(y_upper_setting) + $urandom_range(2) - 1, Y_MAX);
    case ($urandom_range(3))
      0:       z = clamp(int'(z_front_setting) + $urandom_range(2) - 1, Z_MAX);
      1:       z = clamp(int'(z_back_setting) + $urandom_range(2) - 1, Z_MAX);
      2:       z = clamp(int'(z_retract_setting) + $urandom_range(2) - 1, Z_MAX);
      default: z = $urandom_range(Z_MAX);
    endcase
    if ($urandom_range(15) == 0) clock_ms = $urandom();
    queue_tick(4'($urandom_range(15)), $urandom_range(7), y, z);
  endtask

  task automatic queue_random_ticks(input int count);
    int stop_at, pick;
    stop_at = queued_count + count;
    while (queued_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_pick_run();
      end else if (pick < 65) begin
        queue_row_run();
      end else begin
        repeat ($urandom_range(5, 1)) queue_noise();
      end
    end
  endtask

  // Waits until every queued tick has produced its checked result.
  task automatic wait_drained();
    while (checked_count != queued_count) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      gps_pkg::REG_SPEED:        speed_setting        = value[7:0];
      gps_pkg::REG_Y_UPPER:      y_upper_setting      = value[13:0];
      gps_pkg::REG_Z_FRONT:      z_front_setting      = value[11:0];
      gps_pkg::REG_Z_BACK:       z_back_setting       = value[11:0];
      gps_pkg::REG_Z_RETRACT:    z_retract_setting    = value[11:0];
      gps_pkg::REG_LIFT_OFFSET:  lift_offset_setting  = value[11:0];
      gps_pkg::REG_SECOND_DELAY: second_delay_setting = value;
      gps_pkg::REG_REACH_START:  reach_start_setting  = value[11:0];
      default:                   ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] v [8]);
    write_reg(gps_pkg::REG_SPEED,        v[0]);
    write_reg(gps_pkg::REG_Y_UPPER,      v[1]);
    write_reg(gps_pkg::REG_Z_FRONT,      v[2]);
    write_reg(gps_pkg::REG_Z_BACK,       v[3]);
    write_reg(gps_pkg::REG_Z_RETRACT,    v[4]);
    write_reg(gps_pkg::REG_LIFT_OFFSET,  v[5]);
    write_reg(gps_pkg::REG_SECOND_DELAY, v[6]);
    write_reg(gps_pkg::REG_REACH_START,  v[7]);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] vals [8];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset configuration: limits, rows, a full pick
    // and the two tally counts across a wrap of the millisecond time.
    queue_tick_at(gps_pkg::OP_STOP, 0, 0, 0, 32'd0);
    queue_tick(gps_pkg::OP_UP, 0, 4999, 0);
    queue_tick(gps_pkg::OP_UP, 0, 5000, 0);
    queue_tick(gps_pkg::OP_DOWN, 0, Y_MAX, Z_MAX);
    queue_tick(gps_pkg::OP_FORWARD, 0, 0, 874);
    queue_tick(gps_pkg::OP_FORWARD, 0, 0, 875);
    queue_tick(gps_pkg::OP_BACKWARD, 0, 0, 408);
    queue_tick(gps_pkg::OP_BACKWARD, 0, 0, 407);
    queue_tick(gps_pkg::OP_GOTO_ROW, 0, 0, 0);
    queue_tick(gps_pkg::OP_GOTO_ROW, 1, 100, 0);
    queue_tick(gps_pkg::OP_GOTO_ROW, 5, Y_MAX, 0);
    queue_tick(gps_pkg::OP_GOTO_ROW, 3, 2250, 0);
    queue_tick(gps_pkg::OP_GOTO_ROW, 1, 0, 0);
    queue_tick(gps_pkg::OP_CLEAR, 0, 0, 0);
    queue_tick(gps_pkg::OP_PICK, 0, 0, 869);
    queue_tick(gps_pkg::OP_PICK, 0, 1000, 870);
    queue_tick(gps_pkg::OP_PICK, 0, 1300, Z_MAX);
    queue_tick(gps_pkg::OP_PICK, 0, 1300, 411);
    queue_tick(gps_pkg::OP_PICK, 0, 1001, 410);
    queue_tick(gps_pkg::OP_PICK, 0, 1000, 0);
    queue_tick(gps_pkg::OP_PICK, 0, 1000, 0);
    queue_tick(OP_UNUSED_TOP, 7, Y_MAX, Z_MAX);
    queue_tick_at(gps_pkg::OP_RESET, 0, 0, 0, 32'hFFFF_FF00);
    queue_tick(gps_pkg::OP_PICK, 0, 500, 669);
    queue_tick_at(gps_pkg::OP_RESET, 0, 0, 0, 32'hFFFF_FF00 + 32'd2000);
    queue_tick_at(gps_pkg::OP_RESET, 7, Y_MAX, Z_MAX, 32'hFFFF_FF00 + 32'd2001);

    // Random phases: the receiver idles more first, then the sender, then neither.
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg)
        1: vals = '{default: 16'h0000};
        3: vals = '{default: 16'hFFFF};
        2, 4: begin
          foreach (vals[i]) vals[i] = 16'($urandom());
        end
        default: vals = '{16'(gps_pkg::SPEED_RST), 16'(gps_pkg::Y_UPPER_RST),
                          16'(gps_pkg::Z_FRONT_RST), 16'(gps_pkg::Z_BACK_RST),
                          16'(gps_pkg::Z_RETRACT_RST), 16'(gps_pkg::LIFT_OFFSET_RST),
                          gps_pkg::SECOND_DELAY_RST, 16'(gps_pkg::REACH_START_RST)};
      endcase
      apply_settings(vals);
      send_idle_pct = (seg < 2) ? 33 : ((seg < 4) ? 79 : 0);
      recv_idle_pct = (seg < 2) ? 79 : ((seg < 4) ? 33 : 0);
      clock_ms = $urandom();
      // A long receiver hold-off while the sender keeps offering.
      if (seg == 4) hold_requests = hold_requests + 1;
      queue_random_ticks(SEG_ITEMS / 2);
      // The sender pauses here until every result has come back.
      wait_drained();
      queue_random_ticks(SEG_ITEMS / 2);
    end
    wait_drained();

    if (error_count == 0 && expected_axis_status.size() == 0) begin
      $display("gantry_pick_sequencer verification clean");
    end else begin
      $display("gantry_pick_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/gps_pkg.sv
src/gantry_pick_sequencer.sv
src/gantry_pick_sequencer_checker.sv
bench/testbench.sv
